// File: src/bfsp_pkg.sv
// Package: sizes, codes and shared types of the Bellman-Ford shortest path core.
package bfsp_pkg;
   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 512;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int COUNT_W   = 7;
   localparam int EDGE_AW   = $clog2(MAX_EDGES);
   localparam int EDGE_CW   = $clog2(MAX_EDGES + 1);
   localparam int WEIGHT_W  = 24;
   localparam int DIST_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int OP_W      = 2;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNREACH = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NEGCYC  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ACK     = 3'd4;

   localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
   localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

   typedef struct packed {
      logic                       on;
      logic [NODE_W-1:0]          start;
      logic [NODE_W-1:0]          stop;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_type;

   typedef struct packed {
      logic signed [DIST_W-1:0]   dist_u;
      logic signed [WEIGHT_W-1:0] weight;
      logic signed [DIST_W-1:0]   dist_v;
      logic                       reached_v;
   } relax_req_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] cand;
      logic                     take;
   } relax_rsp_type;
endpackage

// File: src/bfsp_ifs.sv
// Interfaces: request, response and configuration channels.
interface bfsp_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [bfsp_pkg::OP_W-1:0]               op;
   logic [bfsp_pkg::NODE_W-1:0]             from_node;
   logic [bfsp_pkg::NODE_W-1:0]             to_node;
   logic signed [bfsp_pkg::WEIGHT_W-1:0]    weight;
   logic                                    edge_enabled;
   modport source (output valid, op, from_node, to_node, weight, edge_enabled, input ready);
   modport sink (input valid, op, from_node, to_node, weight, edge_enabled, output ready);
endinterface

interface bfsp_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [bfsp_pkg::NODE_W-1:0]             path_node;
   logic signed [bfsp_pkg::DIST_W-1:0]      total_distance;
   logic [bfsp_pkg::STATUS_W-1:0]           status;
   logic                                    last;
   modport source (output valid, path_node, total_distance, status, last, input ready);
   modport sink (input valid, path_node, total_distance, status, last, output ready);
endinterface

interface bfsp_csr_if;
   logic                                    valid;
   logic                                    ready;
   logic [bfsp_pkg::COUNT_W-1:0]            node_count;
   modport source (output valid, node_count, input ready);
   modport sink (input valid, node_count, output ready);
endinterface

// File: src/bfsp_ram.sv
// Generic RAM: one write port, one read port with registered data.
module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/bfsp_relax.sv
// Relax unit: saturating distance add and strict compare, registered.
module bfsp_relax (
   input  logic                    clock,
   input  bfsp_pkg::relax_req_type relax_req,
   output bfsp_pkg::relax_rsp_type relax_rsp
);
   logic signed [bfsp_pkg::DIST_W:0]   sum;
   logic signed [bfsp_pkg::DIST_W-1:0] cand;
   bfsp_pkg::relax_rsp_type            relax_rsp_ff;

   always_comb begin
      sum = {relax_req.dist_u[bfsp_pkg::DIST_W-1], relax_req.dist_u}
          + {{(bfsp_pkg::DIST_W + 1 - bfsp_pkg::WEIGHT_W){relax_req.weight[bfsp_pkg::WEIGHT_W-1]}},
             relax_req.weight};
      if (sum[bfsp_pkg::DIST_W] != sum[bfsp_pkg::DIST_W-1]) begin
         cand = sum[bfsp_pkg::DIST_W] ? bfsp_pkg::DIST_MIN : bfsp_pkg::DIST_MAX;
      end else begin
         cand = sum[bfsp_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      relax_rsp_ff.cand <= cand;
      relax_rsp_ff.take <= !relax_req.reached_v || (cand < relax_req.dist_v);
   end

   assign relax_rsp = relax_rsp_ff;
endmodule

// File: src/shortest_path_bellman_ford_core.sv
// Top level: edge table, relaxation sequencer, parent walk and path output.
// Clear and add edge: result in the output register the next cycle.
// Query: each edge is read, then skipped or relaxed; up to node_count sweeps (taken
// as 1 to 64) over the edge memory, ending early once a sweep changes nothing, else
// with a negative-cycle check sweep, then the parent walk over the path nodes and
// the emission of each path node. One item at a time; the edge sweep sets the rate.
// Reset: synchronous, empties the edge table, node_count returns to 64.
module shortest_path_bellman_ford_core (
   input logic         clock,
   input logic         reset,
   bfsp_req_if.sink    req,
   bfsp_rsp_if.source  rsp,
   bfsp_csr_if.sink    csr
);
   typedef enum logic [3:0] {
      S_IDLE, S_SW_RD, S_SW_ED, S_SW_ND, S_SW_CMP, S_PATH,
      S_PW_RD, S_PW_WT, S_EM_RD, S_EM_OUT, S_DONE
   } state_type;

   state_type                            state_ff;
   logic [bfsp_pkg::COUNT_W-1:0]         node_count_ff;
   logic [bfsp_pkg::COUNT_W-1:0]         n_eff;
   logic [bfsp_pkg::EDGE_CW-1:0]         edges_loaded_ff;
   logic [bfsp_pkg::EDGE_CW-1:0]         e_ff;
   logic [bfsp_pkg::MAX_NODES-1:0]       reached_ff;
   logic [bfsp_pkg::NODE_W-1:0]          src_ff, dst_ff, cur_ff, idx_ff;
   logic [bfsp_pkg::COUNT_W-1:0]         pass_ff, len_ff;
   logic                                 check_ff, changed_ff;
   logic signed [bfsp_pkg::DIST_W-1:0]   dist_b_ff, res_dist_ff;
   logic [bfsp_pkg::STATUS_W-1:0]        res_status_ff;

   logic                                 rsp_valid_ff, rsp_last_ff;
   logic [bfsp_pkg::NODE_W-1:0]          rsp_node_ff;
   logic signed [bfsp_pkg::DIST_W-1:0]   rsp_dist_ff;
   logic [bfsp_pkg::STATUS_W-1:0]        rsp_status_ff;

   logic                                 out_free, accept;
   logic                                 edge_wr;
   bfsp_pkg::edge_type                   edge_wdata, edge_q;
   logic [$bits(bfsp_pkg::edge_type)-1:0] edge_q_raw;
   logic                                 node_wr;
   logic [bfsp_pkg::NODE_W-1:0]          node_waddr, parent_wdata, parent_q;
   logic signed [bfsp_pkg::DIST_W-1:0]   dist_wdata, dist_a_q, dist_b_q;
   logic [bfsp_pkg::NODE_W-1:0]          dist_a_addr;
   logic                                 chain_wr;
   logic [bfsp_pkg::NODE_W-1:0]          chain_q;
   logic                                 edge_ok, start_query, query_bad;
   bfsp_pkg::relax_req_type              relax_req;
   bfsp_pkg::relax_rsp_type              relax_rsp;

   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = bfsp_pkg::COUNT_W'(1);
      end else if (node_count_ff > bfsp_pkg::COUNT_W'(bfsp_pkg::MAX_NODES)) begin
         n_eff = bfsp_pkg::COUNT_W'(bfsp_pkg::MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign query_bad   = ({1'b0, req.from_node} >= n_eff) || ({1'b0, req.to_node} >= n_eff);
   assign start_query = accept && (req.op == bfsp_pkg::OP_QUERY) && !query_bad;

   assign edge_wr = accept && (req.op == bfsp_pkg::OP_ADD)
                  && (edges_loaded_ff < bfsp_pkg::EDGE_CW'(bfsp_pkg::MAX_EDGES));
   assign edge_wdata.on     = req.edge_enabled;
   assign edge_wdata.start  = req.from_node;
   assign edge_wdata.stop   = req.to_node;
   assign edge_wdata.weight = req.weight;
   assign edge_q = bfsp_pkg::edge_type'(edge_q_raw);

   assign edge_ok = edge_q.on && ({1'b0, edge_q.start} < n_eff)
                  && ({1'b0, edge_q.stop} < n_eff) && reached_ff[edge_q.start];

   always_comb begin
      node_wr      = 1'b0;
      node_waddr   = req.from_node;
      dist_wdata   = '0;
      parent_wdata = req.from_node;
      if (start_query) begin
         node_wr = 1'b1;
      end else if (state_ff == S_SW_CMP && relax_rsp.take && !check_ff) begin
         node_wr      = 1'b1;
         node_waddr   = edge_q.stop;
         dist_wdata   = relax_rsp.cand;
         parent_wdata = edge_q.start;
      end
   end

   assign dist_a_addr = (state_ff == S_SW_ED) ? edge_q.start : dst_ff;
   assign chain_wr    = (state_ff == S_PW_RD);

   assign relax_req.dist_u    = dist_a_q;
   assign relax_req.weight    = edge_q.weight;
   assign relax_req.dist_v    = dist_b_q;
   assign relax_req.reached_v = reached_ff[edge_q.stop];

   bfsp_ram #(.WIDTH($bits(bfsp_pkg::edge_type)), .DEPTH(bfsp_pkg::MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr (edges_loaded_ff[bfsp_pkg::EDGE_AW-1:0]),
      .wr_data (edge_wdata),
      .rd_addr (e_ff[bfsp_pkg::EDGE_AW-1:0]),
      .rd_data (edge_q_raw)
   );

   bfsp_ram #(.WIDTH(bfsp_pkg::DIST_W), .DEPTH(bfsp_pkg::MAX_NODES)) u_dist_a_ram (
      .clock   (clock),
      .wr_en   (node_wr),
      .wr_addr (node_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_a_addr),
      .rd_data (dist_a_q)
   );

   bfsp_ram #(.WIDTH(bfsp_pkg::DIST_W), .DEPTH(bfsp_pkg::MAX_NODES)) u_dist_b_ram (
      .clock   (clock),
      .wr_en   (node_wr),
      .wr_addr (node_waddr),
      .wr_data (dist_wdata),
      .rd_addr (edge_q.stop),
      .rd_data (dist_b_q)
   );

   bfsp_ram #(.WIDTH(bfsp_pkg::NODE_W), .DEPTH(bfsp_pkg::MAX_NODES)) u_parent_ram (
      .clock   (clock),
      .wr_en   (node_wr),
      .wr_addr (node_waddr),
      .wr_data (parent_wdata),
      .rd_addr (cur_ff),
      .rd_data (parent_q)
   );

   bfsp_ram #(.WIDTH(bfsp_pkg::NODE_W), .DEPTH(bfsp_pkg::MAX_NODES)) u_chain_ram (
      .clock   (clock),
      .wr_en   (chain_wr),
      .wr_addr (len_ff[bfsp_pkg::NODE_W-1:0]),
      .wr_data (cur_ff),
      .rd_addr (idx_ff),
      .rd_data (chain_q)
   );

   bfsp_relax u_relax (
      .clock     (clock),
      .relax_req (relax_req),
      .relax_rsp (relax_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         node_count_ff   <= bfsp_pkg::COUNT_W'(bfsp_pkg::MAX_NODES);
         edges_loaded_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         reached_ff      <= '0;
         e_ff            <= '0;
         pass_ff         <= '0;
         len_ff          <= '0;
         check_ff        <= 1'b0;
         changed_ff      <= 1'b0;
      end else begin
         if (csr.valid) begin
            node_count_ff <= csr.node_count;
         end
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_node_ff   <= '0;
                  rsp_dist_ff   <= '0;
                  rsp_last_ff   <= 1'b1;
                  rsp_status_ff <= bfsp_pkg::ST_ACK;
                  case (req.op)
                     bfsp_pkg::OP_CLEAR: begin
                        edges_loaded_ff <= '0;
                        rsp_valid_ff    <= 1'b1;
                     end
                     bfsp_pkg::OP_ADD: begin
                        rsp_valid_ff <= 1'b1;
                        if (edge_wr) begin
                           edges_loaded_ff <= edges_loaded_ff + 1'b1;
                        end else begin
                           rsp_status_ff <= bfsp_pkg::ST_FULL;
                        end
                     end
                     bfsp_pkg::OP_QUERY: begin
                        if (query_bad) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= bfsp_pkg::ST_UNREACH;
                        end else begin
                           reached_ff <= bfsp_pkg::MAX_NODES'(1) << req.from_node;
                           src_ff     <= req.from_node;
                           dst_ff     <= req.to_node;
                           pass_ff    <= '0;
                           check_ff   <= (n_eff == bfsp_pkg::COUNT_W'(1));
                           changed_ff <= 1'b0;
                           e_ff       <= '0;
                           state_ff   <= S_SW_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SW_RD: begin
               if (e_ff == edges_loaded_ff) begin
                  e_ff       <= '0;
                  changed_ff <= 1'b0;
                  if (check_ff || !changed_ff) begin
                     state_ff <= S_PATH;
                  end else if (pass_ff + bfsp_pkg::COUNT_W'(2) >= n_eff) begin
                     check_ff <= 1'b1;
                  end else begin
                     pass_ff <= pass_ff + 1'b1;
                  end
               end else begin
                  state_ff <= S_SW_ED;
               end
            end
            S_SW_ED: begin
               if (edge_ok) begin
                  state_ff <= S_SW_ND;
               end else begin
                  e_ff     <= e_ff + 1'b1;
                  state_ff <= S_SW_RD;
               end
            end
            S_SW_ND: begin
               state_ff <= S_SW_CMP;
            end
            S_SW_CMP: begin
               e_ff     <= e_ff + 1'b1;
               state_ff <= S_SW_RD;
               if (relax_rsp.take) begin
                  if (check_ff) begin
                     res_status_ff <= bfsp_pkg::ST_NEGCYC;
                     res_dist_ff   <= bfsp_pkg::DIST_MIN;
                     state_ff      <= S_DONE;
                  end else begin
                     reached_ff[edge_q.stop] <= 1'b1;
                     changed_ff              <= 1'b1;
                  end
               end
            end
            S_PATH: begin
               cur_ff <= dst_ff;
               len_ff <= '0;
               if (!reached_ff[dst_ff]) begin
                  res_status_ff <= bfsp_pkg::ST_UNREACH;
                  res_dist_ff   <= '0;
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_PW_RD;
               end
            end
            S_PW_RD: begin
               dist_b_ff <= dist_a_q;
               len_ff    <= len_ff + 1'b1;
               if (cur_ff == src_ff) begin
                  idx_ff   <= len_ff[bfsp_pkg::NODE_W-1:0];
                  state_ff <= S_EM_RD;
               end else if (len_ff + 1'b1 >= n_eff) begin
                  res_status_ff <= bfsp_pkg::ST_NEGCYC;
                  res_dist_ff   <= bfsp_pkg::DIST_MIN;
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_PW_WT;
               end
            end
            S_PW_WT: begin
               cur_ff   <= parent_q;
               state_ff <= S_PW_RD;
            end
            S_EM_RD: begin
               state_ff <= S_EM_OUT;
            end
            S_EM_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_node_ff   <= chain_q;
                  rsp_dist_ff   <= dist_b_ff;
                  rsp_status_ff <= bfsp_pkg::ST_OK;
                  rsp_last_ff   <= (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff - 1'b1;
                     state_ff <= S_EM_RD;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_node_ff   <= '0;
                  rsp_dist_ff   <= res_dist_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.path_node      = rsp_node_ff;
   assign rsp.total_distance = rsp_dist_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.last           = rsp_last_ff;

   a_edges_bound: assert property (@(posedge clock) disable iff (reset)
      edges_loaded_ff <= bfsp_pkg::EDGE_CW'(bfsp_pkg::MAX_EDGES))
      else $error("edge count beyond table size");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != bfsp_pkg::ST_OK) |-> rsp_last_ff)
      else $error("error status on a non-final item");

   a_source_reached: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_RD) |-> reached_ff[src_ff])
      else $error("source node lost its reached mark");

   a_check_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SW_CMP) && !check_ff |-> (pass_ff + bfsp_pkg::COUNT_W'(1) < n_eff))
      else $error("relaxation pass count overrun");
endmodule
